/* src/heap_sift_bottom_up_unit_assert.svh */
// assertion macros for the heap sift unit
`ifndef HEAP_SIFT_BOTTOM_UP_UNIT_ASSERT_SVH
`define HEAP_SIFT_BOTTOM_UP_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clock, disabled during reset
`define HSBU_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, disabled during reset
`define HSBU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/hsbu_pkg.sv */
// shared types and constants of the heap sift unit
package hsbu_pkg;

   // default storage geometry
   localparam int DepthDefault    = 1024;
   localparam int KeyWidthDefault = 32;

   // fixed field widths of the request and response words
   localparam int OpWidth    = 2;
   localparam int PosWidth   = 10;
   localparam int ValWidth   = 32;
   localparam int SizeWidth  = 11;
   localparam int IdxWidth   = 11;
   localparam int ChildWidth = 12;

   // operation codes
   localparam logic [OpWidth-1:0] OP_WRITE = 2'd0;
   localparam logic [OpWidth-1:0] OP_READ  = 2'd1;
   localparam logic [OpWidth-1:0] OP_SIFT  = 2'd2;

   // request word
   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [PosWidth-1:0]  position;
      logic [ValWidth-1:0]  value;
      logic [SizeWidth-1:0] heap_size;
   } req_type;

   // response word
   typedef struct packed {
      logic [ValWidth-1:0] read_value;
      logic [PosWidth-1:0] final_position;
   } rsp_type;

endpackage

/* src/heap_sift_bottom_up_unit.sv */
// top level of the heap sift unit: key store plus bottom-up max-heap sift sequencer
// a write goes to FINISH, a read through RDATA; a sift runs LOAD, then DOWN, LEFT and
// RIGHT per level down, UP and PAR per level up, then FINISH, or FINISH at once when the
// start is outside the heap
// one word at a time; the single ram read port, one entry per cycle, sets the sift time
// reset clears the sequencer, the response valid and key_signed; ram contents are kept
module heap_sift_bottom_up_unit
   import hsbu_pkg::*;
#(
   parameter int DEPTH     = DepthDefault,
   parameter int KEY_WIDTH = KeyWidthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   `include "heap_sift_bottom_up_unit_assert.svh"

   localparam int AW     = $clog2(DEPTH);
   localparam int CntCap = (DEPTH < 2047) ? DEPTH : 2047;

   localparam logic [KEY_WIDTH-1:0] SignBit = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_RDATA  = 9'b000000010,
      ST_LOAD   = 9'b000000100,
      ST_DOWN   = 9'b000001000,
      ST_LEFT   = 9'b000010000,
      ST_RIGHT  = 9'b000100000,
      ST_UP     = 9'b001000000,
      ST_PAR    = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [OpWidth-1:0]   op_ff, op_in;
   logic                 hit_ff, hit_in;
   logic [ValWidth-1:0]  rdval_ff, rdval_in;
   logic [IdxWidth-1:0]  start_ff, start_in;
   logic [IdxWidth-1:0]  count_ff, count_in;
   logic [IdxWidth-1:0]  cur_ff, cur_in;
   logic [KEY_WIDTH-1:0] elem_ff, elem_in;
   logic [KEY_WIDTH-1:0] left_ff, left_in;
   logic                 key_signed_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [KEY_WIDTH-1:0] ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [KEY_WIDTH-1:0] ram_rd_data;

   logic                  accept;
   logic                  out_free;
   logic                  pos_hit;
   logic [IdxWidth-1:0]   size_clamp;
   logic [ChildWidth-1:0] child_w;
   logic [ChildWidth-1:0] left_w;
   logic                  has_child;
   logic                  right_missing;
   logic [IdxWidth-1:0]   parent_w;
   logic                  pick_left;
   logic                  in_down_up;
   logic                  in_up_par;
   logic                  in_finish;

   // compare under the selected key order
   function automatic logic key_less(input logic [KEY_WIDTH-1:0] a,
                                     input logic [KEY_WIDTH-1:0] b,
                                     input logic                 sgn);
      logic [KEY_WIDTH-1:0] flip;
      flip = sgn ? SignBit : '0;
      return (a ^ flip) < (b ^ flip);
   endfunction

   // key store
   hsbu_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // handshake and index arithmetic
   assign accept        = req_valid && !req_stall;
   assign req_stall     = (state_ff != ST_IDLE);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign pos_hit       = (32'(req_data.position) < DEPTH);
   assign size_clamp    = (32'(req_data.heap_size) > CntCap) ? IdxWidth'(CntCap)
                                                             : req_data.heap_size;
   assign child_w       = {cur_ff, 1'b0} + 12'd2;
   assign left_w        = {cur_ff, 1'b0} + 12'd1;
   assign has_child     = (child_w <= {1'b0, count_ff});
   assign right_missing = (child_w == {1'b0, count_ff});
   assign parent_w      = (cur_ff - 11'd1) >> 1;
   assign pick_left     = right_missing || key_less(ram_rd_data, left_ff, key_signed_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hit_in       = hit_ff;
      rdval_in     = rdval_ff;
      start_in     = start_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      elem_in      = elem_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = AW'(cur_ff);
      ram_wr_data  = elem_ff;
      ram_rd_addr  = AW'(cur_ff);

      // response register drains when taken
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_data.operation;
               hit_in      = pos_hit;
               ram_rd_addr = AW'(req_data.position);
               unique case (req_data.operation)
                  OP_WRITE: begin
                     ram_wr_en   = pos_hit;
                     ram_wr_addr = AW'(req_data.position);
                     ram_wr_data = KEY_WIDTH'(req_data.value);
                     state_in    = ST_FINISH;
                  end
                  OP_READ: begin
                     state_in = ST_RDATA;
                  end
                  OP_SIFT: begin
                     start_in = {1'b0, req_data.position};
                     count_in = size_clamp;
                     cur_in   = {1'b0, req_data.position};
                     if ({1'b0, req_data.position} >= size_clamp) begin
                        state_in = ST_FINISH;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_RDATA: begin
            rdval_in = hit_ff ? ValWidth'(ram_rd_data) : '0;
            state_in = ST_FINISH;
         end
         ST_LOAD: begin
            elem_in  = ram_rd_data;
            state_in = ST_DOWN;
         end
         // phase one: fetch left child, then right child
         ST_DOWN: begin
            if (has_child) begin
               ram_rd_addr = AW'(left_w);
               state_in    = ST_LEFT;
            end else begin
               state_in = ST_UP;
            end
         end
         ST_LEFT: begin
            left_in     = ram_rd_data;
            ram_rd_addr = right_missing ? AW'(left_w) : AW'(child_w);
            state_in    = ST_RIGHT;
         end
         // move the larger child into the hole
         ST_RIGHT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(cur_ff);
            ram_wr_data = pick_left ? left_ff : ram_rd_data;
            cur_in      = pick_left ? IdxWidth'(left_w) : IdxWidth'(child_w);
            state_in    = ST_DOWN;
         end
         // phase two: fetch parent or settle at the start
         ST_UP: begin
            if (cur_ff > start_ff) begin
               ram_rd_addr = AW'(parent_w);
               state_in    = ST_PAR;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = AW'(cur_ff);
               ram_wr_data = elem_ff;
               state_in    = ST_FINISH;
            end
         end
         ST_PAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(cur_ff);
            if (key_less(ram_rd_data, elem_ff, key_signed_ff)) begin
               ram_wr_data = ram_rd_data;
               cur_in      = parent_w;
               state_in    = ST_UP;
            end else begin
               ram_wr_data = elem_ff;
               state_in    = ST_FINISH;
            end
         end
         // load the response register
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.read_value      = (op_ff == OP_READ) ? rdval_ff : '0;
               rsp_data_in.final_position  = (op_ff == OP_SIFT) ? PosWidth'(cur_ff) : '0;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_signed_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         key_signed_ff <= csr_data;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      hit_ff      <= hit_in;
      rdval_ff    <= rdval_in;
      start_ff    <= start_in;
      count_ff    <= count_in;
      cur_ff      <= cur_in;
      elem_ff     <= elem_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // state groups watched by the checks
   assign in_down_up = (state_ff == ST_DOWN) || (state_ff == ST_UP);
   assign in_up_par  = (state_ff == ST_UP) || (state_ff == ST_PAR);
   assign in_finish  = (state_ff == ST_FINISH);

   // checks on the sequencer
   `HSBU_ASSERT_NEXT(a_accept_busy, accept, state_ff != ST_IDLE, "accepted word left unit idle")
   `HSBU_ASSERT_NOW(a_cur_in_heap, in_down_up, cur_ff < count_ff, "sift index outside heap")
   `HSBU_ASSERT_NOW(a_cur_above_start, in_up_par, cur_ff >= start_ff, "sift rose above start")
   `HSBU_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid_ff), $past(in_finish), "stray response")

endmodule

/* src/hsbu_ram.sv */
// generic simple dual-port ram with registered read
module hsbu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
